// ----- src/tlvdf_pkg.sv -----
// Package for the TLV deframer with XOR checksum.
// Holds the parse phase type, the result word layout and the known frame types.
// No dependencies.
package tlvdf_pkg;

    typedef enum logic [4:0] {
        PH_TYPE    = 5'b00001,
        PH_LEN_LO  = 5'b00010,
        PH_LEN_HI  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic        checksum_ok;
        logic        type_known;
        logic        length_unexpected;
    } result_t;

    localparam logic [7:0] REQ_ROOM  = 8'd5;
    localparam logic [7:0] REQ_PHONE = 8'd6;
    localparam logic [7:0] REQ_MAP   = 8'd7;
    localparam logic [7:0] REQ_QUIZ  = 8'd8;

    function automatic logic is_known_type(input logic [7:0] t);
        return (t == REQ_ROOM) || (t == REQ_PHONE) ||
               (t == REQ_MAP) || (t == REQ_QUIZ);
    endfunction

endpackage

// ----- src/tlvdf_if.sv -----
// Valid/ready channel interfaces for the TLV deframer.
// tlvdf_in_if carries received bytes, tlvdf_out_if carries result words.
// No dependencies.
interface tlvdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface tlvdf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic        checksum_ok;
    logic        type_known;
    logic        length_unexpected;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_done, output frame_type, output frame_length,
                    output checksum_ok, output type_known, output length_unexpected,
                    input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_done, input frame_type, input frame_length,
                    input checksum_ok, input type_known, input length_unexpected,
                    output ready);
endinterface

// ----- src/tlv_deframer_xor_check.sv -----
// Top level of the TLV deframer with XOR checksum.
// Depends on tlvdf_pkg and the channel interfaces in tlvdf_if.sv.
//
// Takes one received byte per word on rx and returns exactly one result word per
// byte on res, one byte per clock cycle unless res stalls. Frames are a type byte, a
// little-endian 16-bit length, the payload and an XOR checksum over all preceding
// bytes of the frame. Payload bytes appear with payload_valid set; the checksum byte
// gives frame_done with type, length, checksum_ok, type_known and length_unexpected.
// The parser state is updated in the cycle a byte is taken and the result is
// registered, in the skid register if the result register stalls. A two-entry output
// stage (result register plus skid register) lets rx stay ready while one result
// waits on res; rx.ready drops only when both entries are full.
module tlv_deframer_xor_check (
    input  logic clk,
    input  logic rst_n,
    tlvdf_in_if.sink    rx,
    tlvdf_out_if.source res
);
    import tlvdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  chk_reg, chk_next;
    logic [15:0] remain_dec;
    logic [15:0] len_full;
    logic        known;

    result_t     result_next;
    result_t     out_data_reg;
    result_t     skid_data_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        accept;
    logic        out_free;

    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;
    assign out_free = !out_valid_reg || res.ready;

    assign remain_dec = remain_reg - 16'd1;
    assign len_full   = {rx.byte_in, len_reg[7:0]};
    assign known      = is_known_type(type_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        chk_next    = chk_reg;
        result_next = '0;
        unique case (phase_reg)
            PH_LEN_LO:
            begin
                len_next   = {8'h00, rx.byte_in};
                chk_next   = chk_reg ^ rx.byte_in;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next    = len_full;
                chk_next    = chk_reg ^ rx.byte_in;
                remain_next = len_full;
                phase_next  = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                result_next.payload_byte  = rx.byte_in;
                result_next.payload_valid = 1'b1;
                chk_next    = chk_reg ^ rx.byte_in;
                remain_next = remain_dec;
                if (remain_dec == 16'd0)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                result_next.frame_done        = 1'b1;
                result_next.frame_type        = type_reg;
                result_next.frame_length      = len_reg;
                result_next.checksum_ok       = (chk_reg == rx.byte_in);
                result_next.type_known        = known;
                result_next.length_unexpected = known && (len_reg != 16'd0);
                phase_next  = PH_TYPE;
                chk_next    = 8'h00;
                remain_next = 16'd0;
            end
            default:
            begin
                type_next   = rx.byte_in;
                chk_next    = rx.byte_in;
                len_next    = 16'd0;
                remain_next = 16'd0;
                phase_next  = PH_LEN_LO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= 8'h00;
            len_reg    <= 16'd0;
            remain_reg <= 16'd0;
            chk_reg    <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            chk_reg    <= chk_next;
        end
    end

    // hold a result in the skid entry while the output entry is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= result_next;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= result_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.payload_byte      = out_data_reg.payload_byte;
    assign res.payload_valid     = out_data_reg.payload_valid;
    assign res.frame_done        = out_data_reg.frame_done;
    assign res.frame_type        = out_data_reg.frame_type;
    assign res.frame_length      = out_data_reg.frame_length;
    assign res.checksum_ok       = out_data_reg.checksum_ok;
    assign res.type_known        = out_data_reg.type_known;
    assign res.length_unexpected = out_data_reg.length_unexpected;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output entry empty");

    a_done_excl_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.payload_valid && out_data_reg.frame_done))
        else $error("payload and frame end flagged in one word");

    a_unexp_known: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.length_unexpected) |-> out_data_reg.type_known)
        else $error("length_unexpected set for unknown type");

    a_check_to_type: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_CHECK) |=> (phase_reg == PH_TYPE))
        else $error("checksum byte did not return parser to type phase");

    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_PAYLOAD && remain_reg == 16'd1)
        |=> (phase_reg == PH_CHECK))
        else $error("last payload byte did not move parser to checksum phase");

endmodule

// ----- tb/sv/tb_tlv_deframer_xor_check.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the TLV deframer with XOR checksum: a directed table, then
// random frames, random gaps on both channels, each result word checked by table or predictor.
// Depends on tlvdf_pkg, the channel interfaces in tlvdf_if.sv and tlv_deframer_xor_check.
module tb_tlv_deframer_xor_check;
    import tlvdf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 1260;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } vector_t;

    logic clk;
    logic rst_n;

    tlvdf_in_if  rx_if();
    tlvdf_out_if res_if();

    tlv_deframer_xor_check i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    phase_t      prs_phase;
    logic [7:0]  prs_type;
    logic [15:0] prs_length;
    logic [15:0] prs_left;
    logic [7:0]  prs_xor;

    result_t result_q[$];
    vector_t vector_q[$];

    int  errors        = 0;
    int  cycles        = 0;
    int  bytes_sent    = 0;
    int  frames_closed = 0;
    int  sums_bad      = 0;
    int  requests_seen = 0;
    int  payload_seen  = 0;
    bit  no_idle       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d result words outstanding", $time, result_q.size());
            $display("[tlv_deframer_xor_check] ERROR");
            $finish;
        end
    end

    function automatic bit request_type(input logic [7:0] t);
        case (t)
            REQ_ROOM, REQ_PHONE, REQ_MAP, REQ_QUIZ:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (prs_phase)
            PH_LEN_LO:
            begin
                prs_length = {8'h00, b};
                prs_xor    = prs_xor ^ b;
                prs_phase  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                prs_length = {b, prs_length[7:0]};
                prs_xor    = prs_xor ^ b;
                prs_left   = prs_length;
                prs_phase  = (prs_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                prs_xor         = prs_xor ^ b;
                prs_left        = prs_left - 16'd1;
                if (prs_left == 16'd0)
                    prs_phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                r.frame_done        = 1'b1;
                r.frame_type        = prs_type;
                r.frame_length      = prs_length;
                r.checksum_ok       = (prs_xor == b);
                r.type_known        = request_type(prs_type);
                r.length_unexpected = r.type_known && (prs_length != 16'd0);
                prs_phase           = PH_TYPE;
                prs_xor             = 8'h00;
                prs_left            = 16'd0;
            end
            default:
            begin
                prs_type   = b;
                prs_xor    = b;
                prs_length = 16'd0;
                prs_left   = 16'd0;
                prs_phase  = PH_LEN_LO;
            end
        endcase
        return r;
    endfunction

    function automatic result_t pay_word(input logic [7:0] b);
        result_t r;
        r               = '0;
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        return r;
    endfunction

    function automatic result_t done_word(input logic [7:0] kind, input logic [15:0] len,
                                          input bit ok, input bit known, input bit odd_len);
        result_t r;
        r                   = '0;
        r.frame_done        = 1'b1;
        r.frame_type        = kind;
        r.frame_length      = len;
        r.checksum_ok       = ok;
        r.type_known        = known;
        r.length_unexpected = odd_len;
        return r;
    endfunction

    function automatic bit field_diff(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_row(input logic [7:0] b, input bit typed, input result_t want);
        vector_q.push_back('{data: b, typed: typed, want: want});
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t typed_word = '0);
        int      gap;
        result_t word;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            rx_if.valid <= 1'b0;
        end
        @(negedge clk);
        word = deframe_byte(b);
        result_q.push_back(typed ? typed_word : word);
        rx_if.valid   <= 1'b1;
        rx_if.byte_in <= b;
        bytes_sent++;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
    endtask

    task automatic send_frame(input logic [7:0] kind, input logic [15:0] len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = kind ^ len[7:0] ^ len[15:8];
        send_byte(kind);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat (len)
        begin
            b   = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            send_byte(b);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0:       return REQ_ROOM;
            1:       return REQ_PHONE;
            2:       return REQ_MAP;
            3:       return REQ_QUIZ;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return 16'd0;
        else if (r < 19)
            return 16'($urandom_range(1, 12));
        return 16'($urandom_range(250, 270));
    endfunction

    initial
    begin
        int mark;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.byte_in = 8'h00;
        prs_phase     = PH_TYPE;
        prs_type      = 8'h00;
        prs_length    = 16'd0;
        prs_left      = 16'd0;
        prs_xor       = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // request type, zero length, good checksum
        add_row(REQ_ROOM, 1'b1, '0);
        add_row(8'h00, 1'b1, '0);
        add_row(8'h00, 1'b1, '0);
        add_row(8'h05, 1'b1, done_word(REQ_ROOM, 16'd0, 1'b1, 1'b1, 1'b0));
        // request type with payload, extreme payload bytes
        add_row(REQ_QUIZ, 1'b1, '0);
        add_row(8'h02, 1'b1, '0);
        add_row(8'h00, 1'b1, '0);
        add_row(8'hFF, 1'b1, pay_word(8'hFF));
        add_row(8'h00, 1'b1, pay_word(8'h00));
        add_row(8'hF5, 1'b1, done_word(REQ_QUIZ, 16'd2, 1'b1, 1'b1, 1'b1));
        // bad checksum
        add_row(REQ_PHONE, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'hFF, 1'b1, done_word(REQ_PHONE, 16'd0, 1'b0, 1'b1, 1'b0));
        // unknown type, then a request type with zero length
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h01, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'hAA, 1'b0, '0);
        add_row(8'h54, 1'b1, done_word(8'hFF, 16'd1, 1'b1, 1'b0, 1'b0));
        add_row(REQ_MAP, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h07, 1'b1, done_word(REQ_MAP, 16'd0, 1'b1, 1'b1, 1'b0));

        foreach (vector_q[i])
            send_byte(vector_q[i].data, vector_q[i].typed, vector_q[i].want);

        // both length bytes nonzero
        send_frame(REQ_MAP, 16'h0101, 1'b0);

        mark = bytes_sent;
        while (bytes_sent - mark < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 6) == 0);
            send_frame(pick_type(), pick_length(), $urandom_range(0, 3) == 0);
        end
        no_idle = 1'b0;
        @(negedge clk);
        rx_if.valid <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d bytes sent, %0d payload bytes passed through", bytes_sent, payload_seen);
        $display("%0d frames closed, %0d with bad checksum, %0d of request type",
                 frames_closed, sums_bad, requests_seen);
        if (errors == 0 && result_q.size() == 0)
            $display("[tlv_deframer_xor_check] OK");
        else
            $display("[tlv_deframer_xor_check] ERROR");
        $finish;
    end

    initial
    begin
        int stall;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            repeat (stall)
            begin
                @(negedge clk);
                res_if.ready <= 1'b0;
            end
            @(negedge clk);
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_if.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        bit      bad;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{payload_byte: res_if.payload_byte, payload_valid: res_if.payload_valid,
                    frame_done: res_if.frame_done, frame_type: res_if.frame_type,
                    frame_length: res_if.frame_length, checksum_ok: res_if.checksum_ok,
                    type_known: res_if.type_known,
                    length_unexpected: res_if.length_unexpected};
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word %h with nothing expected", $time, got);
            end
            else
            begin
                want = result_q.pop_front();
                bad  = 1'b0;
                bad |= field_diff("payload_byte", 16'(want.payload_byte),
                                  16'(got.payload_byte));
                bad |= field_diff("payload_valid", 16'(want.payload_valid),
                                  16'(got.payload_valid));
                bad |= field_diff("frame_done", 16'(want.frame_done), 16'(got.frame_done));
                bad |= field_diff("frame_type", 16'(want.frame_type), 16'(got.frame_type));
                bad |= field_diff("frame_length", want.frame_length, got.frame_length);
                bad |= field_diff("checksum_ok", 16'(want.checksum_ok),
                                  16'(got.checksum_ok));
                bad |= field_diff("type_known", 16'(want.type_known), 16'(got.type_known));
                bad |= field_diff("length_unexpected", 16'(want.length_unexpected),
                                  16'(got.length_unexpected));
                if (bad)
                    errors++;
                if (want.payload_valid)
                    payload_seen++;
                if (want.frame_done)
                begin
                    frames_closed++;
                    if (!want.checksum_ok)
                        sums_bad++;
                    if (want.type_known)
                        requests_seen++;
                end
            end
        end
    end

endmodule
